// ----- rtl/core/bsfd_pkg.sv -----
// Shared types, constants and row-command codes for the B-spline forward
// differencing tessellator. No dependencies; every other file in rtl/core uses it.
package bsfd_pkg;

  localparam int COORD_W      = 32;  // Q16.16 coordinate
  localparam int ROW_W        = 48;  // difference row, coordinate scaled by 2^16
  localparam int OPND_W       = 36;  // signed combinations of four coordinates
  localparam int INV_W        = 31;  // unsigned Q1.30 reciprocal
  localparam int PROD_W       = OPND_W + INV_W + 1;
  localparam int SEG_W        = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int INV_FRAC     = 30;
  localparam int GUARD_BITS   = 16;
  localparam int NUM_LANES    = 3;
  localparam int LANE_W       = 2;
  localparam int MAX_SEGMENTS = 16;

  // Fraction bits dropped when a product enters a row
  localparam int DROP_WHOLE = INV_FRAC - GUARD_BITS;      // terms scaled by 6 or 2
  localparam int DROP_HALF  = INV_FRAC + 1 - GUARD_BITS;  // terms halved once more

  // Operation codes of an input item
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_N         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_N_SQUARED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_N_CUBED   = 2'd3;

  localparam logic [SEG_W-1:0] SEGMENTS_RESET = 5'd1;
  localparam logic [INV_W-1:0] INV_ONE        = 31'h4000_0000;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] qz;
    logic                      final_res;
    logic                      status;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [2:0] {
    ROW_HOLD,
    ROW_LOAD_A,   // row0 = row1 = 6a term
    ROW_LOAD_Q,   // row2 = a term, row3 = d
    ROW_ADD_B,    // add the b terms to row1 and row2
    ROW_ADD_C,    // add the c term to row2
    ROW_STEP      // one forward difference step on every lane
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [LANE_W-1:0] lane;
  } row_cmd_t;

endpackage

// ----- rtl/core/bsfd_div3.sv -----
// Registered floor division by three of a signed operand, six bits a digit.
// Depends on bsfd_pkg for the operand width.
module bsfd_div3 (
  input  logic                                clk,
  input  logic signed [bsfd_pkg::OPND_W-1:0]  x,
  output logic signed [bsfd_pkg::OPND_W-1:0]  q,
  output logic [1:0]                          r
);

  localparam int BIASED_W   = bsfd_pkg::OPND_W + 1;
  localparam int DIGIT_W    = 6;
  localparam int NUM_DIGITS = (BIASED_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W      = NUM_DIGITS * DIGIT_W;
  localparam logic [BIASED_W-1:0] BIAS = BIASED_W'(3) << (bsfd_pkg::OPND_W - 1);
  localparam logic [bsfd_pkg::OPND_W-1:0] HALF = bsfd_pkg::OPND_W'(1) << (bsfd_pkg::OPND_W - 1);

  logic [BIASED_W-1:0] biased;
  logic [PAD_W-1:0]    padded;
  logic [PAD_W-1:0]    quo;
  logic [1:0]          rem;

  // Bias by three halves of the range so the dividend is positive; the
  // quotient then carries exactly half the range, removed below.
  always_comb begin
    logic [DIGIT_W+1:0] v;
    logic [16:0]        scaled;
    logic [DIGIT_W-1:0] qd;
    biased = {x[bsfd_pkg::OPND_W-1], x} + BIAS;
    padded = PAD_W'(biased);
    quo    = '0;
    rem    = 2'd0;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      v      = {rem, padded[i*DIGIT_W +: DIGIT_W]};
      scaled = 17'(v) * 17'd171;        // v/3 exactly for v below 192
      qd     = scaled[DIGIT_W+8:9];
      rem    = 2'(v - 8'(qd) * 8'd3);
      quo[i*DIGIT_W +: DIGIT_W] = qd;
    end
  end

  always_ff @(posedge clk) begin
    q <= $signed(quo[bsfd_pkg::OPND_W-1:0] - HALF);
    r <= rem;
  end

endmodule

// ----- rtl/core/bsfd_mul.sv -----
// Shared registered multiplier: signed operand times unsigned Q1.30 reciprocal.
// Depends on bsfd_pkg for operand and product widths.
module bsfd_mul (
  input  logic                                clk,
  input  logic signed [bsfd_pkg::OPND_W-1:0]  a,
  input  logic [bsfd_pkg::INV_W-1:0]          b,
  output logic signed [bsfd_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

// ----- rtl/core/bsfd_rows.sv -----
// Forward difference rows for the three coordinate lanes: loading from products,
// the per-point step and the rounded curve point. Depends on bsfd_pkg.
module bsfd_rows (
  input  logic                                clk,
  input  bsfd_pkg::row_cmd_t                  cmd,
  input  logic signed [bsfd_pkg::PROD_W-1:0]  prod,
  input  logic [32:0]                         ta,
  input  logic [bsfd_pkg::ROW_W-1:0]          dval,
  output bsfd_pkg::point_t                    curve
);

  localparam int ROW_W = bsfd_pkg::ROW_W;
  localparam logic [ROW_W-1:0] OUT_ROUND = ROW_W'(1) << (bsfd_pkg::GUARD_BITS - 1);

  logic [ROW_W-1:0] rows [bsfd_pkg::NUM_LANES][4];
  logic [ROW_W-1:0] t_whole;
  logic [ROW_W-1:0] t_half;
  logic [ROW_W-1:0] t_a1;
  logic [ROW_W-1:0] sum [bsfd_pkg::NUM_LANES];

  function automatic logic [ROW_W-1:0] round_drop(input logic [bsfd_pkg::PROD_W-1:0] p,
                                                  input int unsigned s);
    logic [bsfd_pkg::PROD_W-1:0] t;
    t = (p + (bsfd_pkg::PROD_W'(1) << (s - 1))) >> s;
    return t[ROW_W-1:0];
  endfunction

  assign t_whole = round_drop(prod, bsfd_pkg::DROP_WHOLE);
  assign t_half  = round_drop(prod, bsfd_pkg::DROP_HALF);
  assign t_a1    = round_drop(prod + $signed(bsfd_pkg::PROD_W'(ta)), bsfd_pkg::DROP_HALF);

  // Next row3 of each lane, rounded to the coordinate grid
  always_comb begin
    for (int j = 0; j < bsfd_pkg::NUM_LANES; j++) begin
      sum[j] = rows[j][3] + rows[j][2] + OUT_ROUND;
    end
    curve.x = $signed(sum[0][ROW_W-1:bsfd_pkg::GUARD_BITS]);
    curve.y = $signed(sum[1][ROW_W-1:bsfd_pkg::GUARD_BITS]);
    curve.z = $signed(sum[2][ROW_W-1:bsfd_pkg::GUARD_BITS]);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bsfd_pkg::ROW_LOAD_A: begin
        rows[cmd.lane][0] <= t_whole;
        rows[cmd.lane][1] <= t_whole;
      end
      bsfd_pkg::ROW_LOAD_Q: begin
        rows[cmd.lane][2] <= t_a1;
        rows[cmd.lane][3] <= dval;
      end
      bsfd_pkg::ROW_ADD_B: begin
        rows[cmd.lane][1] <= rows[cmd.lane][1] + t_whole;
        rows[cmd.lane][2] <= rows[cmd.lane][2] + t_half;
      end
      bsfd_pkg::ROW_ADD_C: begin
        rows[cmd.lane][2] <= rows[cmd.lane][2] + t_half;
      end
      bsfd_pkg::ROW_STEP: begin
        for (int j = 0; j < bsfd_pkg::NUM_LANES; j++) begin
          rows[j][3] <= rows[j][3] + rows[j][2];
          rows[j][2] <= rows[j][2] + rows[j][1];
          rows[j][1] <= rows[j][1] + rows[j][0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/bspline_forward_difference.sv -----
// Top level of the uniform cubic B-spline tessellator: sequencer, point window,
// configuration registers and result register. Depends on bsfd_pkg, bsfd_div3,
// bsfd_mul and bsfd_rows.
//
// Usage. Control points enter on the item channel (item_valid / item_stall),
// operation 0 for a point and 1 to close the stream. Curve points leave on the
// result channel (result_valid / result_stall). Configuration registers are
// written through cfg_valid / cfg_ready with cfg_index and cfg_data, between
// transactions; segments, then 1/N, 1/N^2 and 1/N^3 in Q1.30.
// Sequencing. The first four points of a stream only fill the history. Every
// window of four points then loads the difference rows, one multiply at a time
// on the shared multiplier, in S_DIFF to pick up the window and then S_A, S_Q,
// S_B, S_C and S_D per coordinate, and steps the rows once per curve point.
// With segments nonzero, the fifth point runs four windows, each later point
// one and the closing item one; a rejected stream gives one reject result. The
// block takes no new transaction until the last result of the current one sits
// in the result register.
// Reset (rst, synchronous) returns segments to 1, the reciprocals to 1.0, the
// stream to empty and drops any held result. A stalled receiver holds the
// result register, and the sequencer waits before each further curve point.
module bspline_forward_difference #(
  parameter int MAX_SEGMENTS = bsfd_pkg::MAX_SEGMENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  bsfd_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output bsfd_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsfd_pkg::INV_W-1:0]         cfg_data
);

  localparam int OPND_W = bsfd_pkg::OPND_W;
  localparam int SEG_W  = bsfd_pkg::SEG_W;
  localparam int INV_W  = bsfd_pkg::INV_W;
  localparam int LANE_W = bsfd_pkg::LANE_W;
  localparam logic [SEG_W-1:0] SEG_LIMIT = SEG_W'(MAX_SEGMENTS);
  // Low fraction of d = (d6 * 2^15 + 1) / 3 for each remainder of d6 / 3
  localparam logic [14:0] D_LOW_R1 = 15'd10923;
  localparam logic [14:0] D_LOW_R2 = 15'd21845;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_A, S_Q, S_B, S_C, S_D, S_EMIT, S_REJECT
  } state_t;

  typedef enum logic [2:0] {
    W_START0, W_START1, W_START2, W_FULL, W_TAIL
  } win_t;

  state_t                   state;
  win_t                     win;
  logic [LANE_W-1:0]        lane;
  logic [2:0]               points_seen;
  logic [SEG_W-1:0]         seg_count;
  logic [SEG_W-1:0]         steps_left;
  logic [SEG_W-1:0]         segments;
  logic [INV_W-1:0]         inv_n;
  logic [INV_W-1:0]         inv_n_squared;
  logic [INV_W-1:0]         inv_n_cubed;
  bsfd_pkg::point_t         hist [5];
  logic signed [OPND_W-1:0] a6;
  logic signed [OPND_W-1:0] bq;
  logic signed [OPND_W-1:0] cd;
  logic signed [OPND_W-1:0] d6;
  logic [INV_W-1:0]         inv3_q;
  logic [1:0]               inv3_r;
  logic [1:0]               a6_r;

  logic                     item_fire;
  logic                     can_load;
  logic                     last_win;
  logic [SEG_W-1:0]         seg_clamp;
  logic [LANE_W-1:0]        diff_lane;
  bsfd_pkg::point_t         pin;
  bsfd_pkg::point_t         g [4];
  logic signed [OPND_W-1:0] e [4];
  logic signed [OPND_W-1:0] a6_next;
  logic signed [OPND_W-1:0] bq_next;
  logic signed [OPND_W-1:0] cd_next;
  logic signed [OPND_W-1:0] d6_next;
  logic signed [OPND_W-1:0] div_x;
  logic signed [OPND_W-1:0] div_q;
  logic [1:0]               div_r;
  logic signed [OPND_W-1:0] mul_a;
  logic [INV_W-1:0]         mul_b;
  logic signed [bsfd_pkg::PROD_W-1:0] prod;
  bsfd_pkg::row_cmd_t       row_cmd;
  logic [32:0]              ta;
  logic [14:0]              d_low;
  logic [bsfd_pkg::ROW_W-1:0] dval;
  bsfd_pkg::point_t         curve;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign can_load   = !result_valid || !result_stall;
  assign last_win   = (win == W_FULL) || (win == W_TAIL);
  assign seg_clamp  = (segments > SEG_LIMIT) ? SEG_LIMIT : segments;
  assign diff_lane  = (state == S_DIFF) ? lane : lane + LANE_W'(1);
  assign pin        = '{x: item.px, y: item.py, z: item.pz};

  // Pick the four points of the current window from the history slots
  always_comb begin
    case (win)
      W_START0: begin g[0] = hist[0]; g[1] = hist[0]; g[2] = hist[0]; g[3] = hist[1]; end
      W_START1: begin g[0] = hist[0]; g[1] = hist[0]; g[2] = hist[1]; g[3] = hist[2]; end
      W_START2: begin g[0] = hist[0]; g[1] = hist[1]; g[2] = hist[2]; g[3] = hist[3]; end
      W_TAIL:   begin g[0] = hist[2]; g[1] = hist[3]; g[2] = hist[4]; g[3] = hist[4]; end
      default:  begin g[0] = hist[1]; g[1] = hist[2]; g[2] = hist[3]; g[3] = hist[4]; end
    endcase
  end

  // Basis combinations of one coordinate of the window
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (diff_lane)
        2'd0:    e[k] = OPND_W'(g[k].x);
        2'd1:    e[k] = OPND_W'(g[k].y);
        default: e[k] = OPND_W'(g[k].z);
      endcase
    end
    a6_next = e[3] - e[0] + (e[1] - e[2]) * OPND_W'(3);
    bq_next = e[0] - (e[1] <<< 1) + e[2];
    cd_next = e[2] - e[0];
    d6_next = e[0] + (e[1] <<< 2) + e[2];
  end

  // Shared divide-by-three and multiplier operand selection
  always_comb begin
    case (state)
      S_A: begin
        div_x = a6;
        mul_a = a6;
        mul_b = inv_n_cubed;
      end
      S_Q: begin
        div_x = d6;
        mul_a = div_q;
        mul_b = inv_n_cubed;
      end
      S_B: begin
        div_x = $signed(OPND_W'(inv_n_cubed));
        mul_a = bq;
        mul_b = inv_n_squared;
      end
      S_C: begin
        div_x = $signed(OPND_W'(inv_n_cubed));
        mul_a = cd;
        mul_b = inv_n;
      end
      default: begin
        div_x = $signed(OPND_W'(inv_n_cubed));
        mul_a = a6;
        mul_b = inv_n_cubed;
      end
    endcase
  end

  // floor(r * inv3 / 3) from the remainder of a6 and the split of inv3
  always_comb begin
    case (a6_r)
      2'd1:    ta = 33'(inv3_q);
      2'd2:    ta = 33'({inv3_q, 1'b0}) + 33'(inv3_r == 2'd2);
      default: ta = '0;
    endcase
    case (div_r)
      2'd1:    d_low = D_LOW_R1;
      2'd2:    d_low = D_LOW_R2;
      default: d_low = '0;
    endcase
    dval = {div_q[32:0], d_low};
  end

  always_comb begin
    row_cmd.lane = lane;
    case (state)
      S_Q:     row_cmd.op = bsfd_pkg::ROW_LOAD_A;
      S_B:     row_cmd.op = bsfd_pkg::ROW_LOAD_Q;
      S_C:     row_cmd.op = bsfd_pkg::ROW_ADD_B;
      S_D:     row_cmd.op = bsfd_pkg::ROW_ADD_C;
      S_EMIT:  row_cmd.op = can_load ? bsfd_pkg::ROW_STEP : bsfd_pkg::ROW_HOLD;
      default: row_cmd.op = bsfd_pkg::ROW_HOLD;
    endcase
  end

  bsfd_div3 u_div3 (
    .clk (clk),
    .x   (div_x),
    .q   (div_q),
    .r   (div_r)
  );

  bsfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bsfd_rows u_rows (
    .clk   (clk),
    .cmd   (row_cmd),
    .prod  (prod),
    .ta    (ta),
    .dval  (dval),
    .curve (curve)
  );

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      win           <= W_FULL;
      lane          <= '0;
      points_seen   <= '0;
      seg_count     <= '0;
      steps_left    <= '0;
      segments      <= bsfd_pkg::SEGMENTS_RESET;
      inv_n         <= bsfd_pkg::INV_ONE;
      inv_n_squared <= bsfd_pkg::INV_ONE;
      inv_n_cubed   <= bsfd_pkg::INV_ONE;
      result_valid  <= 1'b0;
    end else begin
      // Drain the result register when the receiver takes it
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bsfd_pkg::REG_SEGMENTS:      segments      <= cfg_data[SEG_W-1:0];
          bsfd_pkg::REG_INV_N:         inv_n         <= cfg_data;
          bsfd_pkg::REG_INV_N_SQUARED: inv_n_squared <= cfg_data;
          bsfd_pkg::REG_INV_N_CUBED:   inv_n_cubed   <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_fire) begin
            seg_count <= seg_clamp;
            lane      <= '0;
            if (item.operation == bsfd_pkg::OP_POINT) begin
              if (points_seen < 3'd4) begin
                // Fill the stream's first four slots
                hist[points_seen + 3'd1] <= pin;
                points_seen              <= points_seen + 3'd1;
              end else begin
                // Advance the history by one point
                for (int i = 0; i < 4; i++) begin
                  hist[i] <= hist[i + 1];
                end
                hist[4]     <= pin;
                points_seen <= 3'd5;
                if (seg_clamp != '0) begin
                  win   <= (points_seen == 3'd4) ? W_START0 : W_FULL;
                  state <= S_DIFF;
                end
              end
            end else begin
              points_seen <= '0;
              if (points_seen == 3'd5 && seg_clamp != '0) begin
                win   <= W_TAIL;
                state <= S_DIFF;
              end else begin
                state <= S_REJECT;
              end
            end
          end
        end
        S_DIFF: begin
          a6    <= a6_next;
          bq    <= bq_next;
          cd    <= cd_next;
          d6    <= d6_next;
          state <= S_A;
        end
        S_A: begin
          inv3_q <= div_q[INV_W-1:0];
          inv3_r <= div_r;
          state  <= S_Q;
        end
        S_Q: begin
          a6_r  <= div_r;
          state <= S_B;
        end
        S_B: begin
          state <= S_C;
        end
        S_C: begin
          state <= S_D;
        end
        S_D: begin
          // Pick up the next coordinate while the last product lands
          a6 <= a6_next;
          bq <= bq_next;
          cd <= cd_next;
          d6 <= d6_next;
          if (lane == LANE_W'(bsfd_pkg::NUM_LANES - 1)) begin
            steps_left <= seg_count;
            state      <= S_EMIT;
          end else begin
            lane  <= lane + LANE_W'(1);
            state <= S_A;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            result_valid     <= 1'b1;
            result.qx        <= curve.x;
            result.qy        <= curve.y;
            result.qz        <= curve.z;
            result.final_res <= last_win && (steps_left == SEG_W'(1));
            result.status    <= 1'b0;
            steps_left       <= steps_left - SEG_W'(1);
            if (steps_left == SEG_W'(1)) begin
              if (last_win) begin
                state <= S_IDLE;
              end else begin
                lane  <= '0;
                state <= S_DIFF;
                case (win)
                  W_START0: win <= W_START1;
                  W_START1: win <= W_START2;
                  default:  win <= W_FULL;
                endcase
              end
            end
          end
        end
        S_REJECT: begin
          if (can_load) begin
            result_valid     <= 1'b1;
            result.qx        <= '0;
            result.qy        <= '0;
            result.qz        <= '0;
            result.final_res <= 1'b1;
            result.status    <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An end transaction always restarts the stream
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.operation == bsfd_pkg::OP_END |=> points_seen == '0)
    else $error("stream not restarted after end transaction");

  // Points that only fill the history leave the block idle and add no result
  a_fill_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_fire && item.operation == bsfd_pkg::OP_POINT && points_seen < 3'd4
    |=> !item_stall && $stable(result_valid) || !item_stall && !result_valid)
    else $error("history fill did not return to idle");

  // The emit phase never runs with an empty step count
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> steps_left != '0 && steps_left <= SEG_LIMIT)
    else $error("emit phase with bad step count");

  // A reject result carries no coordinates and closes its transaction
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status
    |-> result.final_res && result.qx == '0 && result.qy == '0 && result.qz == '0)
    else $error("malformed reject result");

  // History never claims more than five points
  a_points_range: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> points_seen <= 3'd5)
    else $error("points_seen out of range");

endmodule

// ----- tb/tb_bspline_forward_difference.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the uniform cubic B-spline tessellator: streams of
// control points against an in-bench forward differencing predictor.
// Depends on bsfd_pkg and bspline_forward_difference.

module tb_bspline_forward_difference;
  import bsfd_pkg::*;

  // Longest span with no transaction on any channel: a drain pause, or the window
  // loads ahead of a curve point, plus a receiver stall. Take it many times.
  localparam int QUIET_LIMIT  = 2000;
  // Idle time before a register write, once every owed curve point has left.
  localparam int DRAIN_CYCLES = 80;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [63:0] ROW_MASK = (64'd1 << ROW_W) - 64'd1;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef bit [63:0] u64_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                ctrl_item    = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              curve_out;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_SEGMENTS;
  logic [INV_W-1:0]     cfg_data     = '0;

  // Predictor copy of the registers and of the point window
  logic [SEG_W-1:0] seg_reg = SEGMENTS_RESET;
  logic [INV_W-1:0] recip1  = INV_ONE;
  logic [INV_W-1:0] recip2  = INV_ONE;
  logic [INV_W-1:0] recip3  = INV_ONE;
  point_t           held [4];
  int               held_count = 0;

  result_t curve_expect [$];  // curve points still owed by the block, oldest first
  result_t item_batch [$];    // curve points of the transaction being predicted
  int      errors      = 0;
  bit      gaps_on     = 1'b1;
  int      stall_left  = 0;
  int      quiet_cycles;

  bspline_forward_difference dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (ctrl_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (curve_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Floor division by three for signed values (division truncates towards zero)
  function automatic longint floor_third(longint v);
    longint q;
    q = v / 3;
    if (v - q * 3 < 0) q = q - 1;
    return q;
  endfunction

  // Round half up while dropping s fraction bits; keep the row width
  function automatic u64_t drop_round(u64_t v, int s);
    return ((v + (64'd1 << (s - 1))) >> s) & ROW_MASK;
  endfunction

  function automatic longint lane_of(point_t p, int c);
    case (c)
      0:       return longint'($signed(p.x));
      1:       return longint'($signed(p.y));
      default: return longint'($signed(p.z));
    endcase
  endfunction

  // Q1.30 reciprocal of d, rounded to nearest
  function automatic logic [INV_W-1:0] recip_of(int unsigned d);
    return INV_W'(((64'd1 << INV_FRAC) + d / 2) / d);
  endfunction

  // Load the difference rows of one window of four points, then step them
  // once per curve point and queue every point on item_batch.
  task automatic trace_window(input point_t g0, input point_t g1, input point_t g2,
                              input point_t g3);
    u64_t        rows [3][4];
    longint      v0, v1, v2, v3, a6, bq, cd, d6, q;
    u64_t        i1, i2, i3, ua6, ubq, ucd, uq, ur;
    logic [31:0] coord [3];
    int          segs;
    result_t     r;
    // segments above the maximum are clamped to the maximum
    segs = (seg_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_reg);
    i1 = recip1;
    i2 = recip2;
    i3 = recip3;
    for (int c = 0; c < 3; c++) begin
      v0 = lane_of(g0, c);
      v1 = lane_of(g1, c);
      v2 = lane_of(g2, c);
      v3 = lane_of(g3, c);
      a6 = -v0 + 3 * v1 - 3 * v2 + v3;
      bq = v0 - 2 * v1 + v2;
      cd = v2 - v0;
      d6 = v0 + 4 * v1 + v2;
      q  = floor_third(a6);
      ua6 = a6;
      ubq = bq;
      ucd = cd;
      uq  = q;
      ur  = a6 - 3 * q;
      rows[c][0] = drop_round(ua6 * i3, DROP_WHOLE);
      rows[c][1] = (rows[c][0] + drop_round(ubq * i2, DROP_WHOLE)) & ROW_MASK;
      // a/6 term: floor the third first, then add the remainder's share
      rows[c][2] = (drop_round(uq * i3 + (ur * i3) / 3, DROP_HALF)
                    + drop_round(ubq * i2, DROP_HALF)
                    + drop_round(ucd * i1, DROP_HALF)) & ROW_MASK;
      rows[c][3] = u64_t'(floor_third(d6 * 32768 + 1)) & ROW_MASK;
    end
    for (int k = 0; k < segs; k++) begin
      for (int c = 0; c < 3; c++) begin
        rows[c][3] = (rows[c][3] + rows[c][2]) & ROW_MASK;
        rows[c][2] = (rows[c][2] + rows[c][1]) & ROW_MASK;
        rows[c][1] = (rows[c][1] + rows[c][0]) & ROW_MASK;
        coord[c] = 32'((((rows[c][3] + (64'd1 << (GUARD_BITS - 1))) & ROW_MASK)
                        >> GUARD_BITS));
      end
      r.qx        = coord[0];
      r.qy        = coord[1];
      r.qz        = coord[2];
      r.final_res = 1'b0;
      r.status    = 1'b0;
      item_batch = {item_batch, r};
    end
  endtask

  // Advance the predictor by one accepted transaction and queue what it owes
  task automatic predict_item(input item_t it);
    point_t  p;
    result_t r;
    item_batch.delete();
    p.x = it.px;
    p.y = it.py;
    p.z = it.pz;
    if (it.operation == OP_POINT) begin
      if (held_count < 4) begin
        // still filling the window: hold the point, emit nothing
        held[held_count] = p;
        held_count++;
      end else begin
        if (held_count == 4) begin
          // fifth point: three start windows repeating the first point, then one full
          trace_window(held[0], held[0], held[0], held[1]);
          trace_window(held[0], held[0], held[1], held[2]);
          trace_window(held[0], held[1], held[2], held[3]);
        end
        trace_window(held[1], held[2], held[3], p);
        held[0]    = held[1];
        held[1]    = held[2];
        held[2]    = held[3];
        held[3]    = p;
        held_count = 5;
      end
    end else begin
      if (held_count == 5 && seg_reg != 0) begin
        // closing window doubles the last point
        trace_window(held[1], held[2], held[3], held[3]);
      end else begin
        // short stream or zero segments: a single reject
        r        = '0;
        r.status = 1'b1;
        item_batch = {item_batch, r};
      end
      held_count = 0;
    end
    if (item_batch.size() != 0) begin
      item_batch[item_batch.size() - 1].final_res = 1'b1;
    end
    curve_expect = {curve_expect, item_batch};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it, then maybe idle
  task automatic send_item(input item_t it);
    item_valid <= 1'b1;
    ctrl_item  <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    predict_item(it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    item_t it;
    it.operation = OP_POINT;
    it.px = x;
    it.py = y;
    it.pz = z;
    send_item(it);
  endtask

  // Close the stream; the coordinates are ignored, so fill them with noise
  task automatic send_end();
    item_t it;
    it.operation = OP_END;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    send_item(it);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      1:       return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [INV_W-1:0] rand_recip();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return INV_ONE;
      default: return INV_W'($urandom_range(0, 1 << INV_FRAC));
    endcase
  endfunction

  task automatic send_rand_point();
    send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // One register write transaction; the caller drops cfg_valid afterwards
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [INV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SEGMENTS:      seg_reg = data[SEG_W-1:0];
      REG_INV_N:         recip1  = data;
      REG_INV_N_SQUARED: recip2  = data;
      REG_INV_N_CUBED:   recip3  = data;
      default:           ;
    endcase
  endtask

  // Wait for the block to go idle, then rewrite all four registers
  task automatic configure(input int unsigned seg, input logic [INV_W-1:0] r1,
                           input logic [INV_W-1:0] r2, input logic [INV_W-1:0] r3);
    item_valid <= 1'b0;
    while (curve_expect.size() != 0) @(posedge clk);
    // idle margin after the last owed curve point, before the writes
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_register(REG_SEGMENTS, INV_W'(seg));
    write_register(REG_INV_N, r1);
    write_register(REG_INV_N_SQUARED, r2);
    write_register(REG_INV_N_CUBED, r3);
    cfg_valid <= 1'b0;
  endtask

  task automatic proper_setting(input int unsigned n);
    configure(n, recip_of(n), recip_of(n * n), recip_of(n * n * n));
  endtask

  task automatic random_setting();
    case ($urandom_range(0, 9))
      5: proper_setting(1);
      6: proper_setting(MAX_SEGMENTS);
      7: configure(0, rand_recip(), rand_recip(), rand_recip());
      // above the maximum: clamped, so pair it with the reciprocals of the maximum
      8: configure($urandom_range(MAX_SEGMENTS + 1, 31), recip_of(MAX_SEGMENTS),
                   recip_of(MAX_SEGMENTS * MAX_SEGMENTS),
                   recip_of(MAX_SEGMENTS * MAX_SEGMENTS * MAX_SEGMENTS));
      // reciprocals are used as written, whatever segments says
      9: configure($urandom_range(1, MAX_SEGMENTS), rand_recip(), rand_recip(),
                   rand_recip());
      default: proper_setting($urandom_range(2, MAX_SEGMENTS - 1));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End with nothing held, then end after two points: both are rejects
  task automatic test_short_streams();
    send_end();
    send_rand_point();
    send_rand_point();
    send_end();
  endtask

  // Reset settings (one curve point per window, reciprocals 1.0) with
  // coordinates at both ends of their range
  task automatic test_coordinate_extremes();
    send_point(C_MAX, C_MIN, 0);
    send_point(C_MIN, C_MAX, -1);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(0, -1, C_MAX);
    send_end();
  endtask

  // Zero segments: the fifth point emits nothing, the end item rejects
  task automatic test_zero_segments();
    configure(0, INV_ONE, INV_ONE, INV_ONE);
    repeat (5) send_rand_point();
    send_end();
  endtask

  // Largest segments code: used as the maximum
  task automatic test_segment_clamp();
    configure(31, recip_of(MAX_SEGMENTS), recip_of(MAX_SEGMENTS * MAX_SEGMENTS),
              recip_of(MAX_SEGMENTS * MAX_SEGMENTS * MAX_SEGMENTS));
    repeat (5) send_rand_point();
    send_end();
  endtask

  // Mostly well-formed streams with random content; some short ones, some
  // settings changed between windows of a running stream
  task automatic test_random_streams();
    int sent;
    int len;
    sent = 0;
    while (sent < 285) begin
      if ($urandom_range(0, 2) == 0) random_setting();
      gaps_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
      for (int i = 0; i < len; i++) begin
        send_rand_point();
        sent++;
        if (i >= 5 && $urandom_range(0, 15) == 0) random_setting();
      end
      send_end();
      sent++;
    end
  endtask

  // Back-to-back transactions with no idling on either side
  task automatic test_steady_stream();
    gaps_on = 1'b0;
    proper_setting(MAX_SEGMENTS);
    repeat (8) send_rand_point();
    send_end();
    proper_setting(3);
    repeat (6) send_rand_point();
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Stall the result channel in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin : check_curve
    result_t want;
    if (!rst && result_valid !== 1'b0 && result_stall === 1'b0) begin
      if (curve_expect.size() == 0) begin
        report_mismatch("unexpected result, qx", curve_out.qx, '0);
      end else begin
        want = curve_expect.pop_front();
        if (curve_out.qx !== want.qx) report_mismatch("qx", curve_out.qx, want.qx);
        if (curve_out.qy !== want.qy) report_mismatch("qy", curve_out.qy, want.qy);
        if (curve_out.qz !== want.qz) report_mismatch("qz", curve_out.qz, want.qz);
        if (curve_out.final_res !== want.final_res)
          report_mismatch("final_res", curve_out.final_res, want.final_res);
        if (curve_out.status !== want.status)
          report_mismatch("status", curve_out.status, want.status);
      end
    end
  end

  // Drop the run once no channel has moved a transaction for too long
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_stall === 1'b0) ||
          (result_valid === 1'b1 && result_stall === 1'b0) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (held[i]) held[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_short_streams();
    test_coordinate_extremes();
    test_zero_segments();
    test_segment_clamp();
    test_random_streams();
    test_steady_stream();

    // Drain: every owed curve point, then a margin for stray results
    item_valid <= 1'b0;
    while (curve_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
